/* sv/keyed_record_table_unit_defines.svh */
// Assertion macros shared by the checker of the keyed record table.
// Depends on nothing; users supply clk and rst in scope.
`ifndef KEYED_RECORD_TABLE_UNIT_DEFINES_SVH
`define KEYED_RECORD_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define KRT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("keyed record table assertion failed");

// Next-cycle implication, disabled during reset.
`define KRT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("keyed record table assertion failed");

`endif

/* sv/krt_pkg.sv */
// Shared types and codes of the keyed record table.
// Used by the controller, the datapath, the top level and the checker.
`default_nettype none
package krt_pkg;

  localparam int KEY_W  = 32;
  localparam int VAL_W  = 32;
  localparam int REC_W  = KEY_W + 2 * VAL_W;

  localparam logic [1:0] OP_CREATE = 2'd0;
  localparam logic [1:0] OP_DUMP   = 2'd1;
  localparam logic [1:0] OP_EDIT   = 2'd2;
  localparam logic [1:0] OP_DELETE = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_INVALID  = 3'd2;
  localparam logic [2:0] ST_DUP      = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;
  localparam logic [2:0] ST_EMPTY    = 3'd5;

  // Output payload sources
  localparam logic [2:0] EM_ECHO = 3'd0;  // request key, zero values
  localparam logic [2:0] EM_NEW  = 3'd1;  // request key and values
  localparam logic [2:0] EM_OLD  = 3'd2;  // request key, stored values
  localparam logic [2:0] EM_REC  = 3'd3;  // stored record
  localparam logic [2:0] EM_ZERO = 3'd4;  // all zero

  typedef struct packed {
    logic       load;
    logic       idx_inc;
    logic       rd_en;
    logic       rd_next;
    logic       wr_en;
    logic       wr_append;
    logic       wr_shift;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       emit;
    logic [2:0] emit_kind;
    logic [2:0] emit_status;
    logic       emit_last;
  } krt_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       cnt_zero;
    logic       full;
    logic       key_bad;
    logic       key_match;
    logic       idx_last;
    logic       out_free;
  } krt_sts_t;

endpackage
`default_nettype wire

/* sv/keyed_record_table_unit.sv */
// Keyed record table: one request stream in, one result stream out.
// Use: each input transaction carries an operation in s_axis_tuser
// (create, dump, edit, delete) and a key and two values in s_axis_tdata.
// Create, edit and delete give one result; dump gives one result per
// stored record, the final one with m_axis_tlast, or a single empty
// status. m_axis_tuser carries the status code.
// Timing: one request at a time; s_axis_tready is high only while idle.
// The record memory has one read port, so a key search reads and then
// compares each entry inspected in turn, a delete reads and writes each
// record moved down, and a dump reads and then emits each record.
// A delete shift starts at the slot where its search ended.
// A result appears in the cycle after it is decided, from an output register.
// Reset empties the table at once (no clearing pass); memory contents
// are left as they are. When the receiver stalls, the current result
// holds in the output register and the next result waits for it.
// Depends on krt_pkg, krt_ctrl and krt_datapath.
`default_nettype none
module keyed_record_table_unit #(
  parameter int CAPACITY = 64
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire [95:0]  s_axis_tdata,   // record_key, first_value, second_value
  input  wire [1:0]   s_axis_tuser,   // operation
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [95:0] m_axis_tdata,   // out_key, out_first, out_second
  output logic [2:0]  m_axis_tuser,   // status
  output logic        m_axis_tlast    // last
);
  import krt_pkg::*;

  krt_cmd_t cmd;
  krt_sts_t sts;

  krt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  krt_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .in_op      (s_axis_tuser),
    .in_rec     (s_axis_tdata),
    .out_ready  (m_axis_tready),
    .out_valid  (m_axis_tvalid),
    .out_status (m_axis_tuser),
    .out_rec    (m_axis_tdata),
    .out_last   (m_axis_tlast)
  );

endmodule
`default_nettype wire

/* sv/krt_ctrl.sv */
// Controller of the keyed record table: sequences search, append, edit,
// delete compaction and dump. Depends on krt_pkg.
`default_nettype none
module krt_ctrl (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  output logic              in_ready,
  input  krt_pkg::krt_sts_t sts,
  output krt_pkg::krt_cmd_t cmd
);
  import krt_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_CMP   = 4'd3;
  localparam logic [3:0] S_DCHK  = 4'd4;
  localparam logic [3:0] S_SHWR  = 4'd5;
  localparam logic [3:0] S_DRD   = 4'd6;
  localparam logic [3:0] S_DEMIT = 4'd7;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.emit_last = 1'b1;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        case (sts.op)
          OP_CREATE: begin
            if (sts.full || sts.key_bad || sts.cnt_zero) begin
              if (sts.out_free) begin
                cmd.emit   = 1'b1;
                state_next = S_IDLE;
                if (sts.full) begin
                  cmd.emit_status = ST_FULL;
                  cmd.emit_kind   = EM_ECHO;
                end else if (sts.key_bad) begin
                  cmd.emit_status = ST_INVALID;
                  cmd.emit_kind   = EM_ECHO;
                end else begin
                  cmd.emit_status = ST_OK;
                  cmd.emit_kind   = EM_NEW;
                  cmd.wr_en       = 1'b1;
                  cmd.wr_append   = 1'b1;
                  cmd.cnt_inc     = 1'b1;
                end
              end
            end else begin
              cmd.rd_en  = 1'b1;
              state_next = S_CMP;
            end
          end
          OP_DUMP: begin
            if (sts.cnt_zero) begin
              if (sts.out_free) begin
                cmd.emit        = 1'b1;
                cmd.emit_status = ST_EMPTY;
                cmd.emit_kind   = EM_ZERO;
                state_next      = S_IDLE;
              end
            end else begin
              cmd.rd_en  = 1'b1;
              state_next = S_DEMIT;
            end
          end
          default: begin
            if (sts.cnt_zero) begin
              if (sts.out_free) begin
                cmd.emit        = 1'b1;
                cmd.emit_status = ST_EMPTY;
                cmd.emit_kind   = EM_ECHO;
                state_next      = S_IDLE;
              end
            end else begin
              cmd.rd_en  = 1'b1;
              state_next = S_CMP;
            end
          end
        endcase
      end
      S_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = S_CMP;
      end
      S_CMP: begin
        if (sts.key_match) begin
          if (sts.out_free) begin
            cmd.emit = 1'b1;
            if (sts.op == OP_CREATE) begin
              cmd.emit_status = ST_DUP;
              cmd.emit_kind   = EM_ECHO;
              state_next      = S_IDLE;
            end else if (sts.op == OP_EDIT) begin
              cmd.emit_status = ST_OK;
              cmd.emit_kind   = EM_OLD;
              cmd.wr_en       = 1'b1;
              state_next      = S_IDLE;
            end else begin
              cmd.emit_status = ST_OK;
              cmd.emit_kind   = EM_OLD;
              state_next      = S_DCHK;
            end
          end
        end else if (!sts.idx_last) begin
          cmd.idx_inc = 1'b1;
          state_next  = S_RD;
        end else if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
          if (sts.op == OP_CREATE) begin
            cmd.emit_status = ST_OK;
            cmd.emit_kind   = EM_NEW;
            cmd.wr_en       = 1'b1;
            cmd.wr_append   = 1'b1;
            cmd.cnt_inc     = 1'b1;
          end else begin
            cmd.emit_status = ST_NOTFOUND;
            cmd.emit_kind   = EM_ECHO;
          end
        end
      end
      S_DCHK: begin
        if (sts.idx_last) begin
          cmd.cnt_dec = 1'b1;
          state_next  = S_IDLE;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_next = 1'b1;
          state_next  = S_SHWR;
        end
      end
      S_SHWR: begin
        cmd.wr_en    = 1'b1;
        cmd.wr_shift = 1'b1;
        cmd.idx_inc  = 1'b1;
        state_next   = S_DCHK;
      end
      S_DRD: begin
        cmd.rd_en  = 1'b1;
        state_next = S_DEMIT;
      end
      S_DEMIT: begin
        if (sts.out_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = ST_OK;
          cmd.emit_kind   = EM_REC;
          cmd.emit_last   = sts.idx_last;
          if (sts.idx_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next  = S_DRD;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

/* sv/krt_datapath.sv */
// Datapath of the keyed record table: request registers, record memory,
// entry count, scan index and output register. Depends on krt_pkg.
`default_nettype none
module krt_datapath #(
  parameter int CAPACITY = 64
) (
  input  wire                            clk,
  input  wire                            rst,
  input  krt_pkg::krt_cmd_t              cmd,
  output krt_pkg::krt_sts_t              sts,
  input  wire [1:0]                      in_op,
  input  wire [krt_pkg::REC_W-1:0]       in_rec,
  input  wire                            out_ready,
  output logic                           out_valid,
  output logic [2:0]                     out_status,
  output logic [krt_pkg::REC_W-1:0]      out_rec,
  output logic                           out_last
);
  import krt_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic [1:0]       req_op;
  logic [REC_W-1:0] req_rec;
  logic [CW-1:0]    count;
  logic [IW-1:0]    idx;
  logic [REC_W-1:0] mem [CAPACITY];
  logic [REC_W-1:0] rdata;
  logic [IW-1:0]    raddr;
  logic [IW-1:0]    waddr;
  logic [REC_W-1:0] wdata;
  logic [REC_W-1:0] emit_rec;
  logic [CW-1:0]    idx_ext;
  logic [KEY_W-1:0] req_key;

  assign req_key = req_rec[KEY_W-1:0];
  assign idx_ext = CW'(idx);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_op  <= in_op;
      req_rec <= in_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      idx   <= '0;
    end else begin
      if (cmd.cnt_inc) begin
        count <= count + CW'(1);
      end else if (cmd.cnt_dec) begin
        count <= count - CW'(1);
      end
      if (cmd.load) begin
        idx <= '0;
      end else if (cmd.idx_inc) begin
        idx <= idx + IW'(1);
      end
    end
  end

  assign raddr = cmd.rd_next ? (idx + IW'(1)) : idx;
  assign waddr = cmd.wr_append ? count[IW-1:0] : idx;
  assign wdata = cmd.wr_shift ? rdata : req_rec;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rdata <= mem[raddr];
    end
  end

  always_comb begin
    case (cmd.emit_kind)
      EM_ECHO: emit_rec = {{(2 * VAL_W){1'b0}}, req_key};
      EM_NEW:  emit_rec = req_rec;
      EM_OLD:  emit_rec = {rdata[REC_W-1:KEY_W], req_key};
      EM_REC:  emit_rec = rdata;
      default: emit_rec = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status <= cmd.emit_status;
      out_rec    <= emit_rec;
      out_last   <= cmd.emit_last;
    end
  end

  assign sts.op        = req_op;
  assign sts.cnt_zero  = (count == '0);
  assign sts.full      = (count >= CW'(CAPACITY));
  assign sts.key_bad   = (req_key == '0) || req_key[KEY_W-1];
  assign sts.key_match = (rdata[KEY_W-1:0] == req_key);
  assign sts.idx_last  = ((idx_ext + CW'(1)) == count);
  assign sts.out_free  = !out_valid || out_ready;

endmodule
`default_nettype wire

/* sv/krt_checker.sv */
// Port-level checker of the keyed record table, bound to the top level.
// Depends on krt_pkg and keyed_record_table_unit_defines.svh.
`default_nettype none
`include "keyed_record_table_unit_defines.svh"
module krt_checker (
  input wire        clk,
  input wire        rst,
  input wire        s_axis_tvalid,
  input wire        s_axis_tready,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready,
  input wire [95:0] m_axis_tdata,
  input wire [2:0]  m_axis_tuser,
  input wire        m_axis_tlast
);
  import krt_pkg::*;

  // stalled result holds
  `KRT_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))

  // error and empty statuses are single results
  `KRT_ASSERT_IMP(a_err_last, m_axis_tvalid && (m_axis_tuser != ST_OK), m_axis_tlast)

  // error and empty statuses carry zero values
  `KRT_ASSERT_IMP(a_err_zero, m_axis_tvalid && (m_axis_tuser != ST_OK), m_axis_tdata[95:32] == 64'd0)

  // one request at a time
  `KRT_ASSERT_NXT(a_one_req, s_axis_tvalid && s_axis_tready, !s_axis_tready)

endmodule

bind keyed_record_table_unit krt_checker u_krt_checker (.*);
`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 100ps
// Testbench of keyed_record_table_unit: directed and random create, dump, edit and
// delete transactions, with every result checked against a behavioral copy of the table.
// Depends on krt_pkg and the keyed_record_table_unit RTL.
module tb;
  import krt_pkg::*;

  localparam int CAPACITY     = 64;
  localparam int RANDOM_ITEMS = 250;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int MAX_REPORTS  = 10;
  localparam int TAIL_CYCLES  = 300;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] rec_key;
    logic [31:0] val_a;
    logic [31:0] val_b;
    logic        tail;
  } table_result_t;

  typedef enum {PH_FILL, PH_MIXED, PH_DRAIN} phase_t;

  class record_table_scoreboard;
    logic [31:0]   keys [CAPACITY];
    logic [31:0]   firsts [CAPACITY];
    logic [31:0]   seconds [CAPACITY];
    int            held;
    int            mismatches;
    table_result_t expected_q [$];

    function new();
      held = 0;
      mismatches = 0;
    endfunction

    function int find_slot(logic [31:0] key);
      for (int i = 0; i < held; i++)
        if (keys[i] == key) return i;
      return -1;
    endfunction

    function void push(logic [2:0] st, logic [31:0] k, logic [31:0] a, logic [31:0] b,
                       logic t);
      table_result_t r;
      r.status  = st;
      r.rec_key = k;
      r.val_a   = a;
      r.val_b   = b;
      r.tail    = t;
      expected_q.push_back(r);
    endfunction

    function void note_request(logic [1:0] op, logic [31:0] key, logic [31:0] v1,
                               logic [31:0] v2);
      int slot;
      slot = find_slot(key);
      case (op)
        OP_CREATE: begin
          if (held >= CAPACITY) push(ST_FULL, key, '0, '0, 1'b1);
          else if (key == '0 || key[31]) push(ST_INVALID, key, '0, '0, 1'b1);
          else if (slot >= 0) push(ST_DUP, key, '0, '0, 1'b1);
          else begin
            keys[held]    = key;
            firsts[held]  = v1;
            seconds[held] = v2;
            held++;
            push(ST_OK, key, v1, v2, 1'b1);
          end
        end
        OP_DUMP: begin
          if (held == 0) push(ST_EMPTY, '0, '0, '0, 1'b1);
          else
            for (int i = 0; i < held; i++)
              push(ST_OK, keys[i], firsts[i], seconds[i], i == held - 1);
        end
        default: begin
          if (held == 0) push(ST_EMPTY, key, '0, '0, 1'b1);
          else if (slot < 0) push(ST_NOTFOUND, key, '0, '0, 1'b1);
          else begin
            push(ST_OK, key, firsts[slot], seconds[slot], 1'b1);
            if (op == OP_EDIT) begin
              firsts[slot]  = v1;
              seconds[slot] = v2;
            end else begin
              // compact: later records move down one slot
              for (int i = slot; i < held - 1; i++) begin
                keys[i]    = keys[i + 1];
                firsts[i]  = firsts[i + 1];
                seconds[i] = seconds[i + 1];
              end
              held--;
            end
          end
        end
      endcase
    endfunction

    function void report(string what, table_result_t want, table_result_t got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t %s: expected st=%0d key=%h a=%h b=%h last=%b, got st=%0d key=%h a=%h b=%h last=%b",
                 $time, what, want.status, want.rec_key, want.val_a, want.val_b, want.tail,
                 got.status, got.rec_key, got.val_a, got.val_b, got.tail);
    endfunction

    function void check_result(table_result_t got);
      table_result_t want;
      if (expected_q.size() == 0) begin
        report("unexpected result", '0, got);
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status || got.rec_key !== want.rec_key ||
          got.val_a !== want.val_a || got.val_b !== want.val_b || got.tail !== want.tail)
        report("result mismatch", want, got);
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata;   // record_key, first_value, second_value
  logic [1:0]  s_axis_tuser;   // operation
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [95:0] m_axis_tdata;   // out_key, out_first, out_second
  logic [2:0]  m_axis_tuser;   // status
  logic        m_axis_tlast;

  bit                     idle_on;
  record_table_scoreboard sb;

  keyed_record_table_unit #(.CAPACITY(CAPACITY)) uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic logic [31:0] random_word();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'hFFFF_FFFF;
      3: return 32'd0;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_request(input logic [1:0] op, input logic [31:0] key,
                              input logic [31:0] v1, input logic [31:0] v2);
    int gap;
    gap = idle_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {v2, v1, key};
    do @(posedge clk); while (s_axis_tready !== 1'b1);
    sb.note_request(op, key, v1, v2);
  endtask

  // hold off until the table has answered everything sent so far
  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (sb.expected_q.size() != 0);
  endtask

  task automatic run_phase(input phase_t phase, inout int sent);
    int          r;
    int          extra;
    logic [1:0]  op;
    logic [31:0] key;
    extra = 0;
    for (int n = 0; n < 160; n++) begin
      if (sent >= RANDOM_ITEMS) break;
      if (phase == PH_MIXED && n >= 40) break;
      if ((phase == PH_FILL && sb.held == CAPACITY) || (phase == PH_DRAIN && sb.held == 0))
        extra++;
      if (extra > 4) break;
      r = $urandom_range(0, 99);
      case (phase)
        PH_FILL:  op = r < 80 ? OP_CREATE : r < 85 ? OP_DUMP : r < 93 ? OP_EDIT : OP_DELETE;
        PH_DRAIN: op = r < 10 ? OP_CREATE : r < 17 ? OP_DUMP : r < 30 ? OP_EDIT : OP_DELETE;
        default:  op = r < 35 ? OP_CREATE : r < 45 ? OP_DUMP : r < 75 ? OP_EDIT : OP_DELETE;
      endcase
      r = $urandom_range(0, 99);
      if (op == OP_CREATE) begin
        if (r < 60) key = $urandom_range(1, 1000);
        else if (r < 80) key = $urandom() & 32'h7FFF_FFFF;
        else if (r < 90 && sb.held > 0) key = sb.keys[$urandom_range(0, sb.held - 1)];
        else key = random_word();
      end else if (op != OP_DUMP && sb.held > 0 && r < (phase == PH_DRAIN ? 90 : 75)) begin
        key = sb.keys[$urandom_range(0, sb.held - 1)];
      end else if (r < 90) begin
        key = $urandom_range(1, 1000);
      end else begin
        key = random_word();
      end
      send_request(op, key, random_word(), random_word());
      sent++;
      if ($urandom_range(0, 29) == 0) wait_for_results();
    end
  endtask

  initial begin : stimulus
    phase_t phase;
    int     sent;
    sb = new();
    idle_on = 1'b1;
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= OP_CREATE;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // empty table, bad keys, extremes of keys and values
    send_request(OP_DUMP,   32'd0,         32'd0,         32'd0);
    send_request(OP_EDIT,   32'd5,         32'd1,         32'd2);
    send_request(OP_DELETE, 32'hFFFF_FFFF, 32'd0,         32'd0);
    send_request(OP_CREATE, 32'd0,         32'd7,         32'd8);
    send_request(OP_CREATE, 32'hFFFF_FFFF, 32'd7,         32'd8);
    send_request(OP_CREATE, 32'h8000_0000, 32'd7,         32'd8);
    send_request(OP_CREATE, 32'd1,         32'h7FFF_FFFF, 32'h8000_0000);
    send_request(OP_CREATE, 32'h7FFF_FFFF, 32'd0,         32'hFFFF_FFFF);
    send_request(OP_CREATE, 32'd100,       32'hFFFF_FFFF, 32'd100);
    send_request(OP_CREATE, 32'd1,         32'd3,         32'd4);
    send_request(OP_DUMP,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(OP_EDIT,   32'd100,       32'h8000_0000, 32'h7FFF_FFFF);
    send_request(OP_EDIT,   32'd2,         32'd9,         32'd9);
    send_request(OP_DELETE, 32'h8000_0000, 32'd0,         32'd0);
    send_request(OP_DELETE, 32'd1,         32'd0,         32'd0);
    send_request(OP_DUMP,   32'd0,         32'd0,         32'd0);
    send_request(OP_DELETE, 32'd100,       32'd0,         32'd0);
    send_request(OP_EDIT,   32'h7FFF_FFFF, 32'h1234_5678, 32'h8765_4321);
    send_request(OP_DELETE, 32'h7FFF_FFFF, 32'd0,         32'd0);
    send_request(OP_DUMP,   32'd0,         32'd0,         32'd0);
    send_request(OP_CREATE, 32'd100,       32'hFFFF_FFFF, 32'hFFFF_FFFF);
    wait_for_results();

    sent = 0;
    phase = PH_FILL;
    while (sent < RANDOM_ITEMS) begin
      idle_on = ($urandom_range(0, 3) != 0);
      run_phase(phase, sent);
      wait_for_results();
      case (phase)
        PH_FILL:  phase = PH_MIXED;
        PH_MIXED: phase = (sb.held > CAPACITY / 2) ? PH_DRAIN : PH_FILL;
        default:  phase = PH_MIXED;
      endcase
    end

    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0)
      $display("[keyed_record_table_unit] OK");
    else
      $display("[keyed_record_table_unit] ERROR");
    $finish;
  end

  initial begin : result_sink
    int            stall;
    table_result_t got;
    m_axis_tready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = idle_on ? $urandom_range(0, 4) : 0;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (m_axis_tvalid !== 1'b1);
      got.status  = m_axis_tuser;
      got.rec_key = m_axis_tdata[31:0];
      got.val_a   = m_axis_tdata[63:32];
      got.val_b   = m_axis_tdata[95:64];
      got.tail    = m_axis_tlast;
      sb.check_result(got);
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("[keyed_record_table_unit] ERROR");
    $finish;
  end
endmodule
